FILE: src/cls_pkg.sv
package cls_pkg;

    // level count and field widths
    localparam int NUM_LEVELS = 2;
    localparam int LVL_W      = 3;
    localparam int IDX_W      = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int RATE_W     = 54;
    localparam int SIZE_W     = 25;
    localparam int QDEL_W     = 48;
    localparam int CDEL_W     = 40;
    localparam int WGT_W      = 7;
    localparam int NSEC_W     = 30;
    localparam int PROD_W     = SIZE_W + NSEC_W;

    // shared divider widths
    localparam int DVD_W = 64;
    localparam int DVS_W = RATE_W;
    localparam int CNT_W = $clog2(DVD_W);

    // stream packing
    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 8;

    localparam logic [WGT_W-1:0]  WGT_RESET  = 7'd10;
    localparam logic [NSEC_W-1:0] NS_PER_SEC = 30'd1000000000;

    // item kinds carried in s_tuser
    localparam logic OP_SELECT = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CUR,
        S_CUR_W,
        S_UP,
        S_UP_W,
        S_DESC,
        S_DESC_CHK,
        S_DESC_W,
        S_SEL_FIN,
        S_REP,
        S_REP_W,
        S_MAC,
        S_AVG_W,
        S_COMMIT,
        S_DONE
    } cls_state_t;

endpackage

FILE: src/cls_div.sv
module cls_div
    import cls_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        ge        = (trial >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath shift registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: src/compression_level_selector.sv
// compression level selector, one shared bit-serial divider
// divisions: a select needs none on an unmeasured level, else up to
// max(2, NUM_LEVELS) divisions; a report up to two
// throughput: one item at a time; a finished result waits in the output register
// while the next transaction is taken
// reset (rst_n, asynchronous): all rates unmeasured, level 0, no exploration, weight 10
module compression_level_selector
    import cls_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_wr_en,
    input  logic [WGT_W-1:0]     cfg_wr_data,   // avg_weight
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,       // block_size, queue_delay_ns, compress_delay_ns
    input  logic                 s_tuser,       // operation
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,       // chosen_level
    output logic                 m_tuser        // exploring
);

    cls_state_t state_reg, state_next;

    logic [RATE_W-1:0] rate_reg [NUM_LEVELS];
    logic              rate_we;
    logic [IDX_W-1:0]  rate_widx;
    logic [RATE_W-1:0] rate_wdata;

    logic [WGT_W-1:0]  wgt_reg;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic              expl_reg, expl_next;
    logic [LVL_W-1:0]  cur_lvl_reg, cur_lvl_next;
    logic              expl_act_reg, expl_act_next;
    logic [LVL_W-1:0]  pend_lvl_reg, pend_lvl_next;
    logic              pend_expl_reg, pend_expl_next;
    logic [LVL_W-1:0]  res_lvl_reg, res_lvl_next;
    logic              res_expl_reg, res_expl_next;
    logic              out_valid_reg, out_valid_next;
    logic [LVL_W-1:0]  out_lvl_reg, out_lvl_next;
    logic              out_expl_reg, out_expl_next;

    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [QDEL_W-1:0] qdel_reg, qdel_next;
    logic [CDEL_W-1:0] cdel_reg, cdel_next;

    logic [SIZE_W-1:0] in_size;
    logic              accept;

    logic [LVL_W-1:0]  rd_lvl;
    logic [RATE_W-1:0] rd_rate;

    logic                    div_start;
    logic [DVD_W-1:0]        div_dvd;
    logic [DVS_W-1:0]        div_dvs;
    logic                    div_done;
    logic [DVD_W-1:0]        div_q;

    logic [WGT_W-1:0]        wgt_eff;
    logic [WGT_W-1:0]        wgt_m1;
    logic [RATE_W+WGT_W-1:0] prev_mul;
    logic [DVD_W-1:0]        avg_sum;
    logic                    q_lt;
    logic                    q_gt;

    assign in_size  = s_tdata[SIZE_W-1:0];
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // single read port on the rate table
    always_comb
    begin
        case (state_reg)
            S_UP:              rd_lvl = lvl_reg + 1'b1;
            S_REP, S_REP_W,
            S_MAC, S_AVG_W:    rd_lvl = pend_lvl_reg;
            default:           rd_lvl = lvl_reg;
        endcase
    end
    assign rd_rate = rate_reg[rd_lvl[IDX_W-1:0]];

    // running average numerator: sample + old * (n - 1)
    assign wgt_eff  = (wgt_reg == '0) ? WGT_W'(1) : wgt_reg;
    assign wgt_m1   = wgt_eff - 1'b1;
    assign prev_mul = rd_rate * wgt_m1;
    assign avg_sum  = div_q + DVD_W'(prev_mul);

    // predicted time against queue delay
    assign q_lt = (div_q < DVD_W'(qdel_reg));
    assign q_gt = (div_q > DVD_W'(qdel_reg));

    // divider operand selection
    always_comb
    begin
        case (state_reg)
            S_MAC:
            begin
                div_dvd = avg_sum;
                div_dvs = DVS_W'(wgt_eff);
            end
            S_REP:
            begin
                div_dvd = DVD_W'(prod_reg);
                div_dvs = DVS_W'(cdel_reg);
            end
            default:
            begin
                div_dvd = DVD_W'(prod_reg);
                div_dvs = rd_rate;
            end
        endcase
    end

    cls_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    // sequencer: next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        lvl_next       = lvl_reg;
        expl_next      = expl_reg;
        cur_lvl_next   = cur_lvl_reg;
        expl_act_next  = expl_act_reg;
        pend_lvl_next  = pend_lvl_reg;
        pend_expl_next = pend_expl_reg;
        res_lvl_next   = res_lvl_reg;
        res_expl_next  = res_expl_reg;
        out_lvl_next   = out_lvl_reg;
        out_expl_next  = out_expl_reg;
        out_valid_next = out_valid_reg && !m_tready;
        prod_next      = prod_reg;
        qdel_next      = qdel_reg;
        cdel_next      = cdel_reg;
        div_start      = 1'b0;
        rate_we        = 1'b0;
        rate_widx      = pend_lvl_reg[IDX_W-1:0];
        rate_wdata     = div_q[RATE_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    prod_next  = in_size * NS_PER_SEC;
                    qdel_next  = s_tdata[SIZE_W +: QDEL_W];
                    cdel_next  = s_tdata[SIZE_W+QDEL_W +: CDEL_W];
                    lvl_next   = cur_lvl_reg;
                    expl_next  = 1'b0;
                    state_next = (s_tuser == OP_SELECT) ? S_CUR : S_REP;
                end
            end
            // current level: unmeasured keeps it
            S_CUR:
            begin
                if (rd_rate == '0)
                begin
                    state_next = S_SEL_FIN;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_CUR_W;
                end
            end
            S_CUR_W:
            begin
                if (div_done)
                begin
                    state_next = q_lt ? S_UP : S_DESC;
                end
            end
            // try one level up, or explore an unmeasured one
            S_UP:
            begin
                if (lvl_reg == LVL_W'(NUM_LEVELS - 1))
                begin
                    state_next = S_SEL_FIN;
                end
                else if (rd_rate != '0)
                begin
                    div_start  = 1'b1;
                    state_next = S_UP_W;
                end
                else
                begin
                    if (!expl_act_reg)
                    begin
                        expl_act_next = 1'b1;
                        expl_next     = 1'b1;
                        lvl_next      = lvl_reg + 1'b1;
                    end
                    state_next = S_SEL_FIN;
                end
            end
            S_UP_W:
            begin
                if (div_done)
                begin
                    if (q_lt)
                    begin
                        lvl_next = lvl_reg + 1'b1;
                    end
                    state_next = S_SEL_FIN;
                end
            end
            // step down while too slow
            S_DESC:
            begin
                if (q_gt && (lvl_reg != '0))
                begin
                    lvl_next   = lvl_reg - 1'b1;
                    state_next = S_DESC_CHK;
                end
                else
                begin
                    state_next = S_SEL_FIN;
                end
            end
            S_DESC_CHK:
            begin
                if (rd_rate == '0)
                begin
                    state_next = S_SEL_FIN;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DESC_W;
                end
            end
            S_DESC_W:
            begin
                if (div_done)
                begin
                    state_next = S_DESC;
                end
            end
            S_SEL_FIN:
            begin
                pend_lvl_next  = lvl_reg;
                pend_expl_next = expl_reg;
                res_lvl_next   = lvl_reg;
                res_expl_next  = expl_reg;
                state_next     = S_DONE;
            end
            // report: measured rate of the pending block
            S_REP:
            begin
                if (cdel_reg == '0)
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_REP_W;
                end
            end
            // a zero sample leaves the rate untouched
            S_REP_W:
            begin
                if (div_done)
                begin
                    if (div_q == '0)
                    begin
                        state_next = S_COMMIT;
                    end
                    else if (rd_rate == '0)
                    begin
                        rate_we    = 1'b1;
                        state_next = S_COMMIT;
                    end
                    else
                    begin
                        state_next = S_MAC;
                    end
                end
            end
            S_MAC:
            begin
                div_start  = 1'b1;
                state_next = S_AVG_W;
            end
            S_AVG_W:
            begin
                if (div_done)
                begin
                    rate_we    = 1'b1;
                    state_next = S_COMMIT;
                end
            end
            // end exploration or commit the pending level
            S_COMMIT:
            begin
                if (pend_expl_reg)
                begin
                    expl_act_next  = 1'b0;
                    pend_expl_next = 1'b0;
                    res_lvl_next   = cur_lvl_reg;
                end
                else
                begin
                    cur_lvl_next = pend_lvl_reg;
                    res_lvl_next = pend_lvl_reg;
                end
                res_expl_next = 1'b0;
                state_next    = S_DONE;
            end
            // hand the result to the output register
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_lvl_next   = res_lvl_reg;
                    out_expl_next  = res_expl_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wgt_reg       <= WGT_RESET;
            cur_lvl_reg   <= '0;
            expl_act_reg  <= 1'b0;
            pend_lvl_reg  <= '0;
            pend_expl_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_LEVELS; i++)
            begin
                rate_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cur_lvl_reg   <= cur_lvl_next;
            expl_act_reg  <= expl_act_next;
            pend_lvl_reg  <= pend_lvl_next;
            pend_expl_reg <= pend_expl_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                wgt_reg <= cfg_wr_data;
            end
            if (rate_we)
            begin
                rate_reg[rate_widx] <= rate_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        lvl_reg      <= lvl_next;
        expl_reg     <= expl_next;
        res_lvl_reg  <= res_lvl_next;
        res_expl_reg <= res_expl_next;
        out_lvl_reg  <= out_lvl_next;
        out_expl_reg <= out_expl_next;
        prod_reg     <= prod_next;
        qdel_reg     <= qdel_next;
        cdel_reg     <= cdel_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_lvl_reg);
    assign m_tuser  = out_expl_reg;

endmodule
